[rtl/core/cscan_pkg.sv]
`default_nettype none

package cscan_pkg;

  // one byte of text with its end marker
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  // one result item, either a match or an end-of-text summary
  typedef struct packed {
    logic        kind;
    logic [15:0] match_start;
    logic [16:0] match_end;
    logic [15:0] name_length;
    logic [15:0] match_total;
    logic        overflowed;
    logic        final_res;
  } out_item_t;

  // which results one scan step produced
  typedef struct packed {
    logic match_v;
    logic summ_v;
  } step_flags_t;

  localparam logic       KIND_MATCH   = 1'b0;
  localparam logic       KIND_SUMMARY = 1'b1;

  localparam logic [7:0] CHAR_COLON      = 8'h3A;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CHAR_NUL        = 8'h00;

  localparam logic [15:0] NAME_COUNT_MAX  = 16'd65534;
  localparam logic [15:0] MAX_MATCHES_RST = 16'd64;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [0:0] REG_MAX_MATCHES = 1'b0;

  localparam int RESQ_DEPTH = 4;

  function automatic logic is_name_char(input logic [7:0] b);
    logic lower;
    logic upper;
    logic digit;
    lower = (b >= 8'h61) && (b <= 8'h7A);
    upper = (b >= 8'h41) && (b <= 8'h5A);
    digit = (b >= 8'h30) && (b <= 8'h39);
    return lower || upper || digit || (b == CHAR_UNDERSCORE);
  endfunction

endpackage

`default_nettype wire

[rtl/core/cscan_core.sv]
`default_nettype none

module cscan_core #(
  parameter int MAX_TEXT_BYTES = 65536
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step_valid,
  input  wire cscan_pkg::in_item_t   step_item,
  input  wire logic [15:0]           max_matches,
  output cscan_pkg::step_flags_t     step_flags,
  output cscan_pkg::out_item_t       match_item,
  output cscan_pkg::out_item_t       summ_item
);
  import cscan_pkg::*;

  localparam int OFF_LIM_I = (MAX_TEXT_BYTES < 65536) ? MAX_TEXT_BYTES : 65536;
  localparam logic [16:0] OFF_LIM  = 17'(OFF_LIM_I);
  localparam logic [15:0] OFF_LAST = 16'(OFF_LIM_I - 1);

  logic        cand_r, cand_nxt;
  logic [15:0] start_r, start_nxt;
  logic [16:0] pos_r, pos_nxt;
  logic [15:0] nc_r, nc_nxt;
  logic [15:0] found_r, found_nxt;
  logic        ovf_r, ovf_nxt;

  logic [15:0] pos_cur;
  logic        ovf_now;
  logic        byte_nz;
  logic        text_done;
  logic        match_v;

  assign byte_nz   = (step_item.text_byte != CHAR_NUL);
  assign text_done = !byte_nz || step_item.end_of_text;

  always_comb begin
    cand_nxt  = cand_r;
    start_nxt = start_r;
    pos_nxt   = pos_r;
    nc_nxt    = nc_r;
    found_nxt = found_r;
    ovf_nxt   = ovf_r;
    pos_cur   = 16'd0;
    match_v   = 1'b0;

    if (step_valid && byte_nz) begin
      // positions saturate at the offset limit
      if (pos_r >= OFF_LIM) begin
        ovf_nxt = 1'b1;
        pos_cur = OFF_LAST;
      end else begin
        pos_cur = pos_r[15:0];
        pos_nxt = pos_r + 17'd1;
      end

      priority if (found_r >= max_matches) begin
        cand_nxt = 1'b0;
      end else if (step_item.text_byte == CHAR_COLON) begin
        if (cand_r && (nc_r != 16'd0)) begin
          match_v   = 1'b1;
          found_nxt = found_r + 16'd1;
          cand_nxt  = 1'b0;
          nc_nxt    = 16'd0;
        end else begin
          cand_nxt  = 1'b1;
          start_nxt = pos_cur;
          nc_nxt    = 16'd0;
        end
      end else if (cand_r && is_name_char(step_item.text_byte)) begin
        if (nc_r < NAME_COUNT_MAX) begin
          nc_nxt = nc_r + 16'd1;
        end
      end else begin
        cand_nxt = 1'b0;
        nc_nxt   = 16'd0;
      end
    end

    // values seen by this step's results, before any end-of-text clear
    ovf_now = ovf_nxt;

    match_item.kind        = KIND_MATCH;
    match_item.match_start = start_r;
    match_item.match_end   = {1'b0, pos_cur} + 17'd1;
    match_item.name_length = nc_r;
    match_item.match_total = found_nxt;
    match_item.overflowed  = ovf_now;
    match_item.final_res   = !step_item.end_of_text;

    summ_item.kind        = KIND_SUMMARY;
    summ_item.match_start = 16'd0;
    summ_item.match_end   = 17'd0;
    summ_item.name_length = 16'd0;
    summ_item.match_total = found_nxt;
    summ_item.overflowed  = ovf_now;
    summ_item.final_res   = 1'b1;

    step_flags.match_v = match_v;
    step_flags.summ_v  = step_valid && text_done;

    if (step_valid && text_done) begin
      cand_nxt  = 1'b0;
      start_nxt = 16'd0;
      pos_nxt   = 17'd0;
      nc_nxt    = 16'd0;
      found_nxt = 16'd0;
      ovf_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r  <= 1'b0;
      start_r <= 16'd0;
      pos_r   <= 17'd0;
      nc_r    <= 16'd0;
      found_r <= 16'd0;
      ovf_r   <= 1'b0;
    end else begin
      cand_r  <= cand_nxt;
      start_r <= start_nxt;
      pos_r   <= pos_nxt;
      nc_r    <= nc_nxt;
      found_r <= found_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

`ifndef SYNTHESIS
  a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= OFF_LIM)
    else $error("byte position past offset limit");

  a_clear_after_summary: assert property (@(posedge clk) disable iff (!rst_n)
    step_flags.summ_v |=> (pos_r == 17'd0) && (found_r == 16'd0) && !cand_r && !ovf_r)
    else $error("text state not cleared after summary");

  a_match_needs_name: assert property (@(posedge clk) disable iff (!rst_n)
    step_flags.match_v |-> cand_r && (nc_r != 16'd0) && (found_r < max_matches))
    else $error("match without open candidate");
`endif

endmodule

`default_nettype wire

[rtl/core/cscan_resq.sv]
`default_nettype none

module cscan_resq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push_a,
  input  wire cscan_pkg::out_item_t data_a,
  input  wire logic                 push_b,
  input  wire cscan_pkg::out_item_t data_b,
  output logic                      room,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output cscan_pkg::out_item_t      out_data
);
  import cscan_pkg::*;

  localparam int PTR_W = $clog2(RESQ_DEPTH);
  localparam int CNT_W = $clog2(RESQ_DEPTH + 1);

  out_item_t          entry_r [RESQ_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               pop;
  logic [PTR_W-1:0]   wr_ptr_b;

  assign out_valid = (count_r != CNT_W'(0));
  assign out_data  = entry_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  // room for the largest burst one item can cause
  assign room      = (count_r <= CNT_W'(RESQ_DEPTH - 2));
  assign wr_ptr_b  = wr_ptr_r + PTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push_a) + PTR_W'(push_b);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    count_nxt  = count_r + CNT_W'(push_a) + CNT_W'(push_b) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_a) begin
      entry_r[wr_ptr_r] <= data_a;
    end
    if (push_b) begin
      entry_r[wr_ptr_b] <= data_b;
    end
  end

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(RESQ_DEPTH))
    else $error("result queue count out of range");

  a_no_push_without_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_a |-> room)
    else $error("push into full result queue");

  a_b_follows_a: assert property (@(posedge clk) disable iff (!rst_n)
    push_b |-> push_a)
    else $error("second push without first");
`endif

endmodule

`default_nettype wire

[rtl/core/colon_shortcode_scanner.sv]
// colon_shortcode_scanner: finds :name: shortcodes in a byte stream
// input channel: in_valid/in_stall/in_data carry one text byte per item with an
// end-of-text flag; a zero byte also ends the text
// result channel: out_valid/out_stall/out_data carry match items (kind 0) and
// one summary item (kind 1) per text; final_res marks the last result of a byte
// config: apb write of max_matches at byte address 0, readable back on prdata
// an accepted item waits in the input register, is scanned once the result queue
// has room, and its results are then written into the queue behind out_data
// throughput: one byte per cycle while the queue has room; a byte that closes
// a match and ends the text gives two results, which leave the queue one per
// cycle while out_stall is low; rate is set by the combinational scan step
// between the input register and the four-entry result queue; the queue holds
// back the input register when it has fewer than two free slots
// when the receiver stalls, results wait in the queue and bytes keep flowing
// until it has fewer than two free slots, then in_stall rises
// reset clears the text state, empties the queue and sets max_matches to 64
`default_nettype none

module colon_shortcode_scanner #(
  parameter int MAX_TEXT_BYTES = 65536
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,

  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire cscan_pkg::in_item_t                  in_data,

  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output cscan_pkg::out_item_t                      out_data,

  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [cscan_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [cscan_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [cscan_pkg::APB_DATA_W-1:0]          prdata,
  output logic                                      pready
);
  import cscan_pkg::*;

  logic        in_valid_r, in_valid_nxt;
  in_item_t    in_item_r;
  logic        in_accept;
  logic        advance;
  logic        q_room;

  logic [15:0] max_matches_r;
  logic        reg_hit;

  step_flags_t flags;
  out_item_t   match_item;
  out_item_t   summ_item;
  logic        push_a;
  logic        push_b;
  out_item_t   data_a;

  // config port
  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_MAX_MATCHES);
  assign prdata  = reg_hit ? {{(APB_DATA_W-16){1'b0}}, max_matches_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_matches_r <= MAX_MATCHES_RST;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      max_matches_r <= pwdata[15:0];
    end
  end

  // input register
  assign advance      = in_valid_r && q_room;
  assign in_stall     = in_valid_r && !q_room;
  assign in_accept    = in_valid && !in_stall;
  assign in_valid_nxt = in_accept || (in_valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_item_r <= in_data;
    end
  end

  cscan_core #(
    .MAX_TEXT_BYTES(MAX_TEXT_BYTES)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_valid (advance),
    .step_item  (in_item_r),
    .max_matches(max_matches_r),
    .step_flags (flags),
    .match_item (match_item),
    .summ_item  (summ_item)
  );

  // match goes first when a byte gives both results
  assign push_a = flags.match_v || flags.summ_v;
  assign push_b = flags.match_v && flags.summ_v;
  assign data_a = flags.match_v ? match_item : summ_item;

  cscan_resq u_resq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_a   (push_a),
    .data_a   (data_a),
    .push_b   (push_b),
    .data_b   (summ_item),
    .room     (q_room),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

`ifndef SYNTHESIS
  a_held_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_item_r))
    else $error("held input item lost or changed");

  a_step_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    push_a |-> in_valid_r)
    else $error("result produced without an input item");

  a_stalled_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result item lost or changed");
`endif

endmodule

`default_nettype wire
